@@ hdl/smn_pkg.sv @@
// ----------------------------------------------------------------------------
// smn_pkg: shared types and constants for the Sobel magnitude core
// Sizes, request codes, the controller/datapath handshake and Sobel tap tables.
// ----------------------------------------------------------------------------
package smn_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int COL_W       = $clog2(MAX_WIDTH);

  localparam int PIX_W       = 8;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int MAG_W       = 11;
  localparam int ACC_W       = 12;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int NUM_W       = MAG_W + PIX_W;
  localparam int ROOT_STEPS  = SQ_W / 2;
  localparam int RCNT_W      = $clog2(ROOT_STEPS);
  localparam int QCNT_W      = $clog2(PIX_W);
  localparam int TAP_W       = 4;
  localparam int TAP_COUNT   = 9;

  localparam logic [CFG_W-1:0] DIM_MAX_W = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] DIM_MAX_H = CFG_W'(MAX_HEIGHT);
  localparam logic [MAG_W-1:0] MAG_MAX   = '1;

  // request codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_FETCH  = 1'b1;
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_EARLY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // neighbor offset codes
  localparam logic [1:0] OFF_NEG  = 2'b10;
  localparam logic [1:0] OFF_ZERO = 2'b00;
  localparam logic [1:0] OFF_POS  = 2'b01;

  typedef struct packed {
    logic ld;
    logic cstart;
    logic tap;
    logic sq1;
    logic sq2;
    logic root;
    logic wrmag;
    logic divld;
    logic divstep;
    logic emit;
  } smn_cmd_t;

  typedef struct packed {
    logic frame_full;
    logic frame_ready;
    logic tap_last;
    logic root_last;
    logic pix_last;
    logic div_last;
    logic out_free;
  } smn_stat_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [1:0] tap_dr(input logic [TAP_W-1:0] t);
    logic [1:0] r;
    case (t)
      4'd0, 4'd1, 4'd2: r = OFF_NEG;
      4'd6, 4'd7, 4'd8: r = OFF_POS;
      default:          r = OFF_ZERO;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_dc(input logic [TAP_W-1:0] t);
    logic [1:0] r;
    case (t)
      4'd0, 4'd3, 4'd6: r = OFF_NEG;
      4'd2, 4'd5, 4'd8: r = OFF_POS;
      default:          r = OFF_ZERO;
    endcase
    return r;
  endfunction

  // vertical gradient weight: bottom row minus top row, center column doubled
  function automatic logic signed [2:0] tap_wv(input logic [TAP_W-1:0] t);
    logic signed [2:0] r;
    case (t)
      4'd0, 4'd2: r = -3'sd1;
      4'd1:       r = -3'sd2;
      4'd6, 4'd8: r = 3'sd1;
      4'd7:       r = 3'sd2;
      default:    r = 3'sd0;
    endcase
    return r;
  endfunction

  // horizontal gradient weight: left column minus right column, center row doubled
  function automatic logic signed [2:0] tap_wh(input logic [TAP_W-1:0] t);
    logic signed [2:0] r;
    case (t)
      4'd0, 4'd6: r = 3'sd1;
      4'd3:       r = 3'sd2;
      4'd2, 4'd8: r = -3'sd1;
      4'd5:       r = -3'sd2;
      default:    r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] weigh(input logic signed [2:0] k,
                                                    input logic [PIX_W-1:0] p);
    logic signed [ACC_W-1:0] ps;
    logic signed [ACC_W-1:0] r;
    ps = signed'(ACC_W'(p));
    case (k)
      3'sd1:   r = ps;
      3'sd2:   r = ps <<< 1;
      -3'sd1:  r = -ps;
      -3'sd2:  r = -(ps <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/smn_in_if.sv @@
// ----------------------------------------------------------------------------
// smn_in_if: request channel
// Carries load and fetch requests with valid/ready flow control.
// ----------------------------------------------------------------------------
interface smn_in_if import smn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output action, output pixel, input ready);
  modport sink   (input valid, input action, input pixel, output ready);
endinterface

@@ hdl/smn_out_if.sv @@
// ----------------------------------------------------------------------------
// smn_out_if: result channel
// Carries normalized edge values with valid/ready flow control.
// ----------------------------------------------------------------------------
interface smn_out_if import smn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_value;
  logic             frame_last;
  logic             status;

  modport source (output valid, output edge_value, output frame_last, output status,
                  input ready);
  modport sink   (input valid, input edge_value, input frame_last, input status,
                  output ready);
endinterface

@@ hdl/smn_ram.sv @@
// ----------------------------------------------------------------------------
// smn_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/smn_ctrl.sv @@
// ----------------------------------------------------------------------------
// smn_ctrl: sequencer
// Accepts requests and steps the datapath through the frame pass and fetches.
// ----------------------------------------------------------------------------
module smn_ctrl import smn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_ready,
  input  smn_stat_t st,
  output smn_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_TAP   = 10'b0000000010,
    S_DRAIN = 10'b0000000100,
    S_SQ1   = 10'b0000001000,
    S_SQ2   = 10'b0000010000,
    S_ROOT  = 10'b0000100000,
    S_WRMAG = 10'b0001000000,
    S_RDMAG = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } smn_state_t;

  smn_state_t state_r;
  smn_state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_LOAD) begin
            cmd.ld = 1'b1;
            if (st.frame_full) begin
              cmd.cstart = 1'b1;
              state_nxt  = S_TAP;
            end
          end else if (st.frame_ready) begin
            state_nxt = S_RDMAG;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_TAP: begin
        cmd.tap = 1'b1;
        if (st.tap_last) begin
          state_nxt = S_DRAIN;
        end
      end
      // last tap lands in the accumulators here
      S_DRAIN: state_nxt = S_SQ1;
      S_SQ1: begin
        cmd.sq1   = 1'b1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.sq2   = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.root = 1'b1;
        if (st.root_last) begin
          state_nxt = S_WRMAG;
        end
      end
      S_WRMAG: begin
        cmd.wrmag = 1'b1;
        state_nxt = st.pix_last ? S_IDLE : S_TAP;
      end
      S_RDMAG: begin
        cmd.divld = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.divstep = 1'b1;
        if (st.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/smn_datapath.sv @@
// ----------------------------------------------------------------------------
// smn_datapath: stores, gradient, square root and normalizing divider
// Holds the frame and magnitude stores, counters, peak and result register.
// ----------------------------------------------------------------------------
module smn_datapath import smn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smn_cmd_t             cmd,
  output smn_stat_t            st,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [PIX_W-1:0]     out_edge_value,
  output logic                 out_frame_last,
  output logic                 out_status
);

  logic [CFG_W-1:0]        width_r, width_nxt, height_r, height_nxt;
  logic [CNT_W-1:0]        load_count_r, load_count_nxt, read_count_r, read_count_nxt;
  logic [MAG_W-1:0]        peak_r, peak_nxt;
  logic                    frame_ready_r, frame_ready_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ADDR_W-1:0]       p_r, p_nxt;
  logic [TAP_W-1:0]        tap_cnt_r, tap_cnt_nxt;
  logic                    tap_v_r, tap_v_nxt;
  logic signed [2:0]       wv_r, wv_nxt, wh_r, wh_nxt;
  logic signed [ACC_W-1:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [SQ_W-1:0]         prod_r, prod_nxt;
  logic [SQ_W-1:0]         rv_r, rv_nxt, rres_r, rres_nxt, rbit_r, rbit_nxt;
  logic [RCNT_W-1:0]       rcnt_r, rcnt_nxt;
  logic [NUM_W-1:0]        rem_r, rem_nxt;
  logic [PIX_W-1:0]        q_r, q_nxt;
  logic [QCNT_W-1:0]       dcnt_r, dcnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]        edge_r, edge_nxt;
  logic                    last_r, last_nxt, status_r, status_nxt;

  logic [CFG_W-1:0]        w_eff, h_eff;
  logic [2*CFG_W-1:0]      area;
  logic [CNT_W-1:0]        total, ld_base, ld_next;
  logic                    rd_last;
  logic [1:0]              tdr, tdc;
  logic                    row_ok, col_ok;
  logic [ADDR_W-1:0]       w16, roff, coff, tap_addr;
  logic [PIX_W-1:0]        pix_rdata;
  logic [MAG_W-1:0]        mag_rdata, mag_w, ax, ay;
  logic signed [ACC_W-1:0] gx_abs, gy_abs;
  logic [SQ_W-1:0]         rsum;
  logic [NUM_W-1:0]        trial;

  assign w_eff   = clamp_dim(width_r, DIM_MAX_W);
  assign h_eff   = clamp_dim(height_r, DIM_MAX_H);
  assign area    = w_eff * h_eff;
  assign total   = area[CNT_W-1:0];
  assign ld_base = frame_ready_r ? '0 : load_count_r;
  assign ld_next = ld_base + CNT_W'(1);
  assign rd_last = (read_count_r + CNT_W'(1)) >= total;

  // neighbor address and border test for the current tap
  assign tdr = tap_dr(tap_cnt_r);
  assign tdc = tap_dc(tap_cnt_r);
  assign w16 = ADDR_W'(w_eff);

  always_comb begin
    case (tdr)
      OFF_NEG: begin
        row_ok = (row_r != '0);
        roff   = ADDR_W'(0) - w16;
      end
      OFF_POS: begin
        row_ok = ({1'b0, row_r} + CFG_W'(1)) < h_eff;
        roff   = w16;
      end
      default: begin
        row_ok = 1'b1;
        roff   = '0;
      end
    endcase
    case (tdc)
      OFF_NEG: begin
        col_ok = (col_r != '0);
        coff   = '1;
      end
      OFF_POS: begin
        col_ok = ({1'b0, col_r} + CFG_W'(1)) < w_eff;
        coff   = ADDR_W'(1);
      end
      default: begin
        col_ok = 1'b1;
        coff   = '0;
      end
    endcase
  end

  assign tap_addr = p_r + roff + coff;

  assign gx_abs = gx_r[ACC_W-1] ? -gx_r : gx_r;
  assign gy_abs = gy_r[ACC_W-1] ? -gy_r : gy_r;
  assign ax     = gx_abs[MAG_W-1:0];
  assign ay     = gy_abs[MAG_W-1:0];
  assign rsum   = rres_r + rbit_r;
  assign mag_w  = (rres_r > SQ_W'(MAG_MAX)) ? MAG_MAX : rres_r[MAG_W-1:0];
  assign trial  = NUM_W'(peak_r) << dcnt_r;

  smn_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_pix_ram (
    .clk   (clk),
    .we    (cmd.ld),
    .waddr (ld_base[ADDR_W-1:0]),
    .wdata (in_pixel),
    .raddr (tap_addr),
    .rdata (pix_rdata)
  );

  smn_ram #(.WIDTH(MAG_W), .DEPTH(STORE_DEPTH)) u_mag_ram (
    .clk   (clk),
    .we    (cmd.wrmag),
    .waddr (p_r),
    .wdata (mag_w),
    .raddr (read_count_r[ADDR_W-1:0]),
    .rdata (mag_rdata)
  );

  always_comb begin
    st.frame_full  = ld_next >= total;
    st.frame_ready = frame_ready_r;
    st.tap_last    = (tap_cnt_r == TAP_W'(TAP_COUNT - 1));
    st.root_last   = (rcnt_r == '0);
    st.pix_last    = ({1'b0, p_r} + CNT_W'(1)) == total;
    st.div_last    = (dcnt_r == '0);
    st.out_free    = !out_valid_r || out_ready;
  end

  always_comb begin
    width_nxt       = width_r;
    height_nxt      = height_r;
    load_count_nxt  = load_count_r;
    read_count_nxt  = read_count_r;
    peak_nxt        = peak_r;
    frame_ready_nxt = frame_ready_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    p_nxt           = p_r;
    tap_cnt_nxt     = tap_cnt_r;
    tap_v_nxt       = 1'b0;
    wv_nxt          = wv_r;
    wh_nxt          = wh_r;
    gx_nxt          = gx_r;
    gy_nxt          = gy_r;
    prod_nxt        = prod_r;
    rv_nxt          = rv_r;
    rres_nxt        = rres_r;
    rbit_nxt        = rbit_r;
    rcnt_nxt        = rcnt_r;
    rem_nxt         = rem_r;
    q_nxt           = q_r;
    dcnt_nxt        = dcnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    edge_nxt        = edge_r;
    last_nxt        = last_r;
    status_nxt      = status_r;

    // tap data arrives from the registered store read, in the cycle after its address
    if (tap_v_r) begin
      gx_nxt = gx_r + weigh(wh_r, pix_rdata);
      gy_nxt = gy_r + weigh(wv_r, pix_rdata);
    end

    if (cmd.ld) begin
      if (frame_ready_r) begin
        read_count_nxt  = '0;
        peak_nxt        = MAG_W'(1);
        frame_ready_nxt = 1'b0;
      end
      load_count_nxt = ld_next;
    end

    if (cmd.cstart) begin
      row_nxt     = '0;
      col_nxt     = '0;
      p_nxt       = '0;
      tap_cnt_nxt = '0;
      gx_nxt      = '0;
      gy_nxt      = '0;
      peak_nxt    = MAG_W'(1);
    end

    if (cmd.tap) begin
      tap_v_nxt   = row_ok && col_ok;
      wv_nxt      = tap_wv(tap_cnt_r);
      wh_nxt      = tap_wh(tap_cnt_r);
      tap_cnt_nxt = tap_cnt_r + TAP_W'(1);
    end

    if (cmd.sq1) begin
      prod_nxt = ax * ax;
    end

    if (cmd.sq2) begin
      rv_nxt   = prod_r + ay * ay;
      rres_nxt = '0;
      rbit_nxt = SQ_W'(1) << (SQ_W - 2);
      rcnt_nxt = RCNT_W'(ROOT_STEPS - 1);
    end

    // one result bit per cycle
    if (cmd.root) begin
      if (rv_r >= rsum) begin
        rv_nxt   = rv_r - rsum;
        rres_nxt = (rres_r >> 1) + rbit_r;
      end else begin
        rres_nxt = rres_r >> 1;
      end
      rbit_nxt = rbit_r >> 2;
      rcnt_nxt = rcnt_r - RCNT_W'(1);
    end

    if (cmd.wrmag) begin
      if (mag_w > peak_r) begin
        peak_nxt = mag_w;
      end
      tap_cnt_nxt = '0;
      gx_nxt      = '0;
      gy_nxt      = '0;
      p_nxt       = p_r + ADDR_W'(1);
      if ({1'b0, col_r} == (w_eff - CFG_W'(1))) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      if (st.pix_last) begin
        frame_ready_nxt = 1'b1;
        read_count_nxt  = '0;
      end
    end

    if (cmd.divld) begin
      rem_nxt  = {mag_rdata, {PIX_W{1'b0}}} - NUM_W'(mag_rdata);
      q_nxt    = '0;
      dcnt_nxt = QCNT_W'(PIX_W - 1);
    end

    // restoring divide; quotient fits since no magnitude exceeds the peak
    if (cmd.divstep) begin
      if (rem_r >= trial) begin
        rem_nxt       = rem_r - trial;
        q_nxt[dcnt_r] = 1'b1;
      end
      dcnt_nxt = dcnt_r - QCNT_W'(1);
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (frame_ready_r) begin
        edge_nxt       = q_r;
        last_nxt       = rd_last;
        status_nxt     = STAT_OK;
        read_count_nxt = read_count_r + CNT_W'(1);
        if (rd_last) begin
          load_count_nxt  = '0;
          read_count_nxt  = '0;
          peak_nxt        = MAG_W'(1);
          frame_ready_nxt = 1'b0;
        end
      end else begin
        edge_nxt   = '0;
        last_nxt   = 1'b0;
        status_nxt = STAT_EARLY;
      end
    end

    // any register write drops the frame in progress
    if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_nxt  = cfg_wdata;
        REG_HEIGHT: height_nxt = cfg_wdata;
        default:    width_nxt  = width_r;
      endcase
      load_count_nxt  = '0;
      read_count_nxt  = '0;
      peak_nxt        = MAG_W'(1);
      frame_ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= DIM_MAX_W;
      height_r      <= DIM_MAX_H;
      load_count_r  <= '0;
      read_count_r  <= '0;
      peak_r        <= MAG_W'(1);
      frame_ready_r <= 1'b0;
      tap_v_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      load_count_r  <= load_count_nxt;
      read_count_r  <= read_count_nxt;
      peak_r        <= peak_nxt;
      frame_ready_r <= frame_ready_nxt;
      tap_v_r       <= tap_v_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    p_r       <= p_nxt;
    tap_cnt_r <= tap_cnt_nxt;
    wv_r      <= wv_nxt;
    wh_r      <= wh_nxt;
    gx_r      <= gx_nxt;
    gy_r      <= gy_nxt;
    prod_r    <= prod_nxt;
    rv_r      <= rv_nxt;
    rres_r    <= rres_nxt;
    rbit_r    <= rbit_nxt;
    rcnt_r    <= rcnt_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    dcnt_r    <= dcnt_nxt;
    edge_r    <= edge_nxt;
    last_r    <= last_nxt;
    status_r  <= status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_edge_value = edge_r;
  assign out_frame_last = last_r;
  assign out_status     = status_r;

`ifndef NO_ASSERTIONS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result written over a waiting result");

  a_peak_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wrmag && !cfg_we) |=> (peak_r >= $past(mag_w)))
    else $error("peak below a stored magnitude");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && frame_ready_r && rd_last) |=> (!frame_ready_r && read_count_r == '0))
    else $error("frame not closed after final fetch");

  a_tap_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tap |-> (tap_cnt_r < TAP_W'(TAP_COUNT)))
    else $error("tap counter ran past the window");
`endif

endmodule

@@ hdl/sobel_magnitude_normalize_core.sv @@
// ----------------------------------------------------------------------------
// sobel_magnitude_normalize_core: 3x3 Sobel magnitude with peak normalization
// Load: one pixel per cycle until the final load starts the frame pass; no result.
// Frame pass after the final load, per pixel: 9 tap reads from the
//   single pixel store port, drain, two squares, 11-step square root, write.
// Fetch: store read, 8-step divider, emit (held while the result slot is full);
//   the next request is accepted after the emit. Early fetch goes straight to emit.
// Synchronous active-low reset; the stores are not cleared.
// ----------------------------------------------------------------------------
module sobel_magnitude_normalize_core import smn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  smn_in_if.sink               in_ch,
  smn_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  smn_cmd_t  cmd;
  smn_stat_t st;

  smn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  smn_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_pixel       (in_ch.pixel),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_edge_value (out_ch.edge_value),
    .out_frame_last (out_ch.frame_last),
    .out_status     (out_ch.status)
  );

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: Sobel magnitude core check
// Runs directed and random load/fetch requests against an internal frame
// predictor, with random idling on both channels, and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import smn_pkg::*;

  localparam int IDLE_LIMIT   = 40000;
  localparam int RANDOM_ITEMS = 1350;

  typedef struct {
    logic [PIX_W-1:0] edge_value;
    logic             frame_last;
    logic             status;
  } edge_res_t;

  typedef enum {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_W-1:0]       value;
    logic                   action;
    logic [PIX_W-1:0]       pixel;
    bit                     typed;
    edge_res_t              result;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  smn_in_if  in_ch ();
  smn_out_if out_ch ();

  sobel_magnitude_normalize_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // frame predictor state
  logic [CFG_W-1:0] reg_width;
  logic [CFG_W-1:0] reg_height;
  logic [PIX_W-1:0] pixel_mem [STORE_DEPTH];
  int               magnitude_mem [STORE_DEPTH];
  int               loaded;
  int               fetched;
  int               peak;
  bit               edges_ready;

  edge_res_t pending_edges[$];
  stim_row_t stim_table[$];
  int        err_count;
  int        req_count;
  int        result_count;
  int        frame_count;
  int        idle_cycles;
  bit        calm;

  function automatic int eff_dim(logic [CFG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int frame_total();
    return eff_dim(reg_width, MAX_WIDTH) * eff_dim(reg_height, MAX_HEIGHT);
  endfunction

  function automatic void restart_frame();
    loaded = 0;
    fetched = 0;
    peak = 1;
    edges_ready = 0;
  endfunction

  function automatic int tap(int r, int c, int w, int h);
    if (r < 0 || c < 0 || r >= h || c >= w) return 0;
    return int'(pixel_mem[r * w + c]);
  endfunction

  function automatic int floor_root(int v);
    int m;
    m = 0;
    while ((m + 1) * (m + 1) <= v) m++;
    return m;
  endfunction

  function automatic void compute_edge_map();
    int w;
    int h;
    int gv;
    int gh;
    int m;
    w = eff_dim(reg_width, MAX_WIDTH);
    h = eff_dim(reg_height, MAX_HEIGHT);
    peak = 1;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        gv = -tap(r-1, c-1, w, h) - 2 * tap(r-1, c, w, h) - tap(r-1, c+1, w, h)
             + tap(r+1, c-1, w, h) + 2 * tap(r+1, c, w, h) + tap(r+1, c+1, w, h);
        gh = tap(r-1, c-1, w, h) + 2 * tap(r, c-1, w, h) + tap(r+1, c-1, w, h)
             - tap(r-1, c+1, w, h) - 2 * tap(r, c+1, w, h) - tap(r+1, c+1, w, h);
        m = floor_root(gv * gv + gh * gh);
        if (m > 2047) m = 2047;
        if (m > peak) peak = m;
        magnitude_mem[r * w + c] = m;
      end
    end
  endfunction

  // advance the predictor by one accepted request; a fetch yields a result
  function automatic edge_res_t predict_edge(logic action, logic [PIX_W-1:0] pixel);
    edge_res_t res;
    int total;
    int val;
    total = frame_total();
    res.edge_value = '0;
    res.frame_last = 1'b0;
    res.status = STAT_OK;
    if (action == ACT_LOAD) begin
      if (edges_ready) restart_frame();
      if (loaded < total) pixel_mem[loaded] = pixel;
      loaded++;
      if (loaded >= total) begin
        compute_edge_map();
        edges_ready = 1;
        fetched = 0;
      end
    end else if (!edges_ready) begin
      res.status = STAT_EARLY;
    end else begin
      val = magnitude_mem[fetched] * 255 / peak;
      if (val > 255) val = 255;
      res.edge_value = PIX_W'(val);
      res.frame_last = (fetched + 1 >= total);
      fetched++;
      if (res.frame_last) restart_frame();
    end
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             result_count);
    err_count++;
  endtask

  // drain results, then hold off until the core is back to idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    do @(posedge clk); while (!in_ch.ready);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_WIDTH) reg_width = val;
    else reg_height = val;
    restart_frame();
  endtask

  task automatic send_request(logic action, logic [PIX_W-1:0] pixel, bit typed,
                              edge_res_t typed_res);
    int gap;
    edge_res_t res;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= action;
    in_ch.pixel <= pixel;
    do @(posedge clk); while (!in_ch.ready);
    req_count++;
    res = predict_edge(action, pixel);
    if (action == ACT_FETCH) pending_edges.push_back(typed ? typed_res : res);
  endtask

  function automatic logic [PIX_W-1:0] draw_pixel(int style);
    case (style)
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t row;
    row = '{kind: ROW_CFG, index: idx, value: val, action: ACT_LOAD, pixel: '0,
            typed: 0, result: '{'0, 1'b0, STAT_OK}};
    stim_table.push_back(row);
  endtask

  task automatic add_req(logic action, logic [PIX_W-1:0] pixel, bit typed,
                         logic [PIX_W-1:0] ev, logic fl, logic st);
    stim_row_t row;
    row = '{kind: ROW_REQ, index: REG_WIDTH, value: '0, action: action, pixel: pixel,
            typed: typed, result: '{ev, fl, st}};
    stim_table.push_back(row);
  endtask

  // result side
  initial begin
    int stall;
    edge_res_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      result_count++;
      if (pending_edges.size() == 0) begin
        report("unexpected result, edge_value", out_ch.edge_value, 0);
      end else begin
        want = pending_edges.pop_front();
        if (out_ch.edge_value !== want.edge_value)
          report("edge_value", out_ch.edge_value, want.edge_value);
        if (out_ch.frame_last !== want.frame_last)
          report("frame_last", out_ch.frame_last, want.frame_last);
        if (out_ch.status !== want.status)
          report("status", out_ch.status, want.status);
      end
    end
  end

  // watchdog on stalled traffic
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    edge_res_t none;
    int total;
    int nfetch;
    int style;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    none = '{'0, 1'b0, STAT_OK};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_LOAD;
    in_ch.pixel <= '0;
    err_count = 0;
    req_count = 0;
    result_count = 0;
    frame_count = 0;
    calm = 0;
    reg_width = CFG_W'(MAX_WIDTH);
    reg_height = CFG_W'(MAX_HEIGHT);
    restart_frame();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 3x3 frame, early fetches, 1x1 frame from zero sizes, abandoned frame
    add_cfg(REG_WIDTH, 9'd3);
    add_cfg(REG_HEIGHT, 9'd3);
    add_req(ACT_FETCH, '0, 1, '0, 1'b0, STAT_EARLY);
    for (int i = 0; i < 9; i++)
      add_req(ACT_LOAD, (i % 2 == 1 || i == 4) ? 8'hFF : 8'h00, 0, '0, 1'b0, STAT_OK);
    for (int i = 0; i < 9; i++) add_req(ACT_FETCH, '0, 0, '0, 1'b0, STAT_OK);
    add_req(ACT_FETCH, '0, 1, '0, 1'b0, STAT_EARLY);
    add_cfg(REG_WIDTH, 9'd0);
    add_cfg(REG_HEIGHT, 9'd0);
    add_req(ACT_LOAD, 8'hFF, 0, '0, 1'b0, STAT_OK);
    add_req(ACT_FETCH, '0, 1, '0, 1'b1, STAT_OK);
    add_req(ACT_FETCH, '0, 1, '0, 1'b0, STAT_EARLY);
    add_cfg(REG_WIDTH, 9'd2);
    add_cfg(REG_HEIGHT, 9'd2);
    add_req(ACT_LOAD, 8'h5A, 0, '0, 1'b0, STAT_OK);
    add_req(ACT_LOAD, 8'hA5, 0, '0, 1'b0, STAT_OK);
    add_cfg(REG_WIDTH, 9'd2);
    add_req(ACT_FETCH, '0, 1, '0, 1'b0, STAT_EARLY);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        settle();
        write_reg(stim_table[i].index, stim_table[i].value);
      end else begin
        send_request(stim_table[i].action, stim_table[i].pixel, stim_table[i].typed,
                     stim_table[i].result);
      end
    end

    // random frames: mostly complete load/fetch sequences, some noise and breaks
    while (req_count < RANDOM_ITEMS) begin
      frame_count++;
      if (frame_count == 3 || frame_count == 7 || $urandom_range(0, 1)) begin
        w = CFG_W'($urandom_range(1, 8));
        h = CFG_W'($urandom_range(1, 8));
        if (frame_count == 3) begin
          w = 9'd511;
          h = 9'd1;
        end else if (frame_count == 7) begin
          w = 9'd1;
          h = 9'd256;
        end
        settle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
      end
      calm = ($urandom_range(0, 4) == 0);
      style = $urandom_range(0, 5);
      total = frame_total();
      for (int i = 0; i < total; i++) begin
        if ($urandom_range(0, 19) == 0) send_request(ACT_FETCH, '0, 0, none);
        send_request(ACT_LOAD, draw_pixel(style), 0, none);
      end
      nfetch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
      for (int i = 0; i < nfetch; i++) send_request(ACT_FETCH, '0, 0, none);
      if ($urandom_range(0, 6) == 0) send_request(ACT_FETCH, '0, 0, none);
    end
    calm = 0;

    in_ch.valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d requests and %0d results over %0d random frames,", req_count,
             result_count, frame_count);
    $display("including sizes from 1x1 to full width and height, early and cut-short reads.");
    if (err_count == 0 && pending_edges.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
